// File: sv/rgbhm_pkg.sv
// Package for the RGB to hue and magnitude block: field widths, hue segment
// codes and the elaboration-time builder of the lightness-to-magnitude table.
// Depends on nothing; used by rgb_to_hue_and_magnitude_top.
package rgbhm_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SUM_W      = LEVEL_W + 1;
  localparam int unsigned DIFF_W     = LEVEL_W + 1;
  localparam int unsigned HUE_W      = 9;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned DIVIDEND_W = 18;
  localparam int unsigned DIVISOR_W  = LEVEL_W + 1;
  localparam int unsigned DIV_STEPS  = HUE_W;

  // Hue offsets in degrees for each segment of the color wheel.
  localparam logic [HUE_W-1:0] HUE_BASE_RED_UP   = 9'd360;
  localparam logic [HUE_W-1:0] HUE_BASE_RED_DOWN = 9'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN    = 9'd240;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE     = 9'd120;
  localparam logic [15:0]      HUE_STEP          = 16'd60;

  // Gray input is divided as 720 / 2 so that it comes out as 360.
  localparam logic [DIVIDEND_W-1:0] GRAY_DIVIDEND = 18'd720;
  localparam logic [DIVISOR_W-1:0]  GRAY_DIVISOR  = 9'd2;

  // The table covers sums 256 to 511; all smaller sums map to the full magnitude.
  localparam int unsigned MAG_TABLE_AW    = 8;
  localparam int unsigned MAG_TABLE_DEPTH = 1 << MAG_TABLE_AW;
  localparam int unsigned MAG_TABLE_BASE  = 256;

  localparam logic [63:0] LH_DIVISOR     = 64'd102;
  localparam logic [63:0] LOG_DEN        = 64'd3200;
  localparam logic [63:0] LOG10_OF_2_Q32 = 64'd1292913987;
  localparam int          LOG_FRAC_BITS  = 28;

  typedef enum logic [1:0] {
    SEG_RED_UP,
    SEG_RED_DOWN,
    SEG_GREEN,
    SEG_BLUE
  } hue_seg_e;

  typedef logic [MAG_W-1:0] mag_table_t [MAG_TABLE_DEPTH];

  // Evaluated once at elaboration. Lightness in hundredths of a percent is
  // derived from the sum of max and min, then mapped through a fixed-point
  // log10 built by repeated squaring of a Q30 mantissa.
  function automatic mag_table_t build_mag_table(input int unsigned frac_bits);
    mag_table_t  tbl;
    logic [63:0] full;
    logic [63:0] s;
    logic [63:0] lh;
    logic [63:0] num;
    logic [63:0] m;
    logic [63:0] l2;
    logic [63:0] t;
    logic [63:0] res;
    int unsigned k;
    full = 64'd100 << frac_bits;
    for (int e = 0; e < MAG_TABLE_DEPTH; e++) begin
      s  = 64'(MAG_TABLE_BASE + e);
      lh = (64'd2000 * s + 64'd51) / LH_DIVISOR;
      if (lh <= 64'd5800) begin
        res = full;
      end else if (lh >= 64'd9000) begin
        res = 64'd0;
      end else begin
        num = 64'd3200 + 64'd9 * (lh - 64'd5800);
        k = 0;
        for (int j = 0; j < 3; j++) begin
          if (k == j && num >= (LOG_DEN << (j + 1))) begin
            k = j + 1;
          end
        end
        m  = (num << (30 - k)) / LOG_DEN;
        l2 = 64'(k) << LOG_FRAC_BITS;
        for (int i = LOG_FRAC_BITS - 1; i >= 0; i--) begin
          m = (m * m) >> 30;
          if (m >= (64'd2 << 30)) begin
            m  = m >> 1;
            l2 = l2 | (64'd1 << i);
          end
        end
        t = (l2 * LOG10_OF_2_Q32) >> LOG_FRAC_BITS;
        if (t >= (64'd1 << 32)) begin
          res = 64'd0;
        end else begin
          res = (full * ((64'd1 << 32) - t) + (64'd1 << 31)) >> 32;
        end
      end
      tbl[e] = res[MAG_W-1:0];
    end
    return tbl;
  endfunction

endpackage

// File: sv/rgb_to_hue_and_magnitude_top.sv
// Top level of the RGB to hue and magnitude block: max/min stage, hue numerator
// and magnitude lookup stage, then a pipelined restoring divider for the hue.
// Depends on rgbhm_pkg.
//
// Usage:
//   The input channel takes one color (red, green, blue levels) per item with
//   valid_i/stall_o; the output channel gives one result per item (inverted
//   hue in degrees, log-mapped lightness with MAG_FRACTION_BITS fraction
//   bits) with valid_o/stall_i. Items leave in the order they arrive.
//   Each item passes through one stage for max/min, one for the hue numerator
//   and table lookup, and nine divider stages that each settle one quotient
//   bit of the hue.
//   Throughput is one item per cycle while the receiver does not stall;
//   every stage is a register with its own valid bit, and the magnitude
//   rides along with the hue through the divider.
//   When the receiver stalls, the held result stays on the output and the
//   stages behind it keep filling any empty slots, so stall_o rises only when
//   every stage holds an item.
//   Reset clears all valid bits; the pipeline is empty and ready right after.
module rgb_to_hue_and_magnitude_top
  import rgbhm_pkg::*;
#(
  parameter int unsigned MAG_FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [LEVEL_W-1:0] red_level_i,
  input  logic [LEVEL_W-1:0] green_level_i,
  input  logic [LEVEL_W-1:0] blue_level_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [HUE_W-1:0]   hue_degrees_o,
  output logic [MAG_W-1:0]   magnitude_o
);

  localparam int unsigned    MagFullRaw = 100 << MAG_FRACTION_BITS;
  localparam logic [MAG_W-1:0] MagFull  = MAG_W'(MagFullRaw);
  localparam mag_table_t     MagTable   = build_mag_table(MAG_FRACTION_BITS);

  // Stage 1 registers.
  logic                    s1_vld_q;
  logic [LEVEL_W-1:0]      s1_delta_q, s1_delta_d;
  logic [SUM_W-1:0]        s1_sum_q, s1_sum_d;
  logic signed [DIFF_W-1:0] s1_diff_q, s1_diff_d;
  hue_seg_e                s1_seg_q, s1_seg_d;

  // Index 0 is the numerator stage, 1 to DIV_STEPS are the divider stages.
  logic                    vld_q   [DIV_STEPS+1];
  logic [DIVIDEND_W-1:0]   rem_q   [DIV_STEPS+1];
  logic [DIVIDEND_W-1:0]   rem_d   [DIV_STEPS+1];
  logic [DIVISOR_W-1:0]    dvs_q   [DIV_STEPS+1];
  logic [HUE_W-1:0]        quo_q   [DIV_STEPS+1];
  logic [HUE_W-1:0]        quo_d   [DIV_STEPS+1];
  logic [MAG_W-1:0]        mag_q   [DIV_STEPS+1];
  logic                    adv     [DIV_STEPS+1];
  logic                    s1_adv;

  logic [LEVEL_W-1:0]      mx, mn;
  logic [HUE_W-1:0]        base;
  logic [16:0]             prod_base;
  logic signed [15:0]      prod_diff;
  logic signed [18:0]      num_s;
  logic [DIVIDEND_W-1:0]   rem0_d;
  logic [DIVISOR_W-1:0]    dvs0_d;
  logic [MAG_W-1:0]        mag0_d;

  // A stage moves forward when it is empty or the stage after it moves.
  always_comb begin
    adv[DIV_STEPS] = !vld_q[DIV_STEPS] || !stall_i;
    for (int j = DIV_STEPS - 1; j >= 0; j--) begin
      adv[j] = !vld_q[j] || adv[j+1];
    end
    s1_adv  = !s1_vld_q || adv[0];
    stall_o = !s1_adv;
  end

  // Max, min and the hue segment. Red wins ties, then green.
  always_comb begin
    mx = red_level_i;
    mn = red_level_i;
    if (green_level_i > mx) mx = green_level_i;
    if (blue_level_i > mx)  mx = blue_level_i;
    if (green_level_i < mn) mn = green_level_i;
    if (blue_level_i < mn)  mn = blue_level_i;
    s1_delta_d = mx - mn;
    s1_sum_d   = {1'b0, mx} + {1'b0, mn};
    if (mx == red_level_i) begin
      s1_seg_d  = (green_level_i >= blue_level_i) ? SEG_RED_UP : SEG_RED_DOWN;
      s1_diff_d = $signed({1'b0, green_level_i}) - $signed({1'b0, blue_level_i});
    end else if (mx == green_level_i) begin
      s1_seg_d  = SEG_GREEN;
      s1_diff_d = $signed({1'b0, blue_level_i}) - $signed({1'b0, red_level_i});
    end else begin
      s1_seg_d  = SEG_BLUE;
      s1_diff_d = $signed({1'b0, red_level_i}) - $signed({1'b0, green_level_i});
    end
  end

  // Hue numerator base*d - 60*diff, which is never negative, and the
  // rounding form (2*num + d) / (2*d).
  always_comb begin
    case (s1_seg_q)
      SEG_RED_UP:   base = HUE_BASE_RED_UP;
      SEG_RED_DOWN: base = HUE_BASE_RED_DOWN;
      SEG_GREEN:    base = HUE_BASE_GREEN;
      SEG_BLUE:     base = HUE_BASE_BLUE;
      default:      base = HUE_BASE_RED_DOWN;
    endcase
    prod_base = 17'(base) * 17'(s1_delta_q);
    prod_diff = $signed({{(16-DIFF_W){s1_diff_q[DIFF_W-1]}}, s1_diff_q})
                * $signed(HUE_STEP);
    num_s     = $signed({2'b00, prod_base}) - $signed({{3{prod_diff[15]}}, prod_diff});
    if (s1_delta_q == '0) begin
      rem0_d = GRAY_DIVIDEND;
      dvs0_d = GRAY_DIVISOR;
    end else begin
      rem0_d = {num_s[16:0], 1'b0} + {{(DIVIDEND_W-LEVEL_W){1'b0}}, s1_delta_q};
      dvs0_d = {s1_delta_q, 1'b0};
    end
    mag0_d = s1_sum_q[SUM_W-1] ? MagTable[s1_sum_q[MAG_TABLE_AW-1:0]] : MagFull;
  end

  // One quotient bit per divider stage, most significant first.
  always_comb begin
    logic [DIVIDEND_W-1:0] shifted;
    rem_d[0] = rem0_d;
    quo_d[0] = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      shifted = DIVIDEND_W'(dvs_q[j]) << (DIV_STEPS - 1 - j);
      if (rem_q[j] >= shifted) begin
        rem_d[j+1] = rem_q[j] - shifted;
        quo_d[j+1] = {quo_q[j][HUE_W-2:0], 1'b1};
      end else begin
        rem_d[j+1] = rem_q[j];
        quo_d[j+1] = {quo_q[j][HUE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else begin
      if (s1_adv) s1_vld_q <= valid_i;
      if (adv[0]) vld_q[0] <= s1_vld_q;
      for (int j = 1; j <= DIV_STEPS; j++) begin
        if (adv[j]) vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_delta_q <= s1_delta_d;
      s1_sum_q   <= s1_sum_d;
      s1_diff_q  <= s1_diff_d;
      s1_seg_q   <= s1_seg_d;
    end
    if (adv[0]) begin
      rem_q[0] <= rem_d[0];
      dvs_q[0] <= dvs0_d;
      quo_q[0] <= quo_d[0];
      mag_q[0] <= mag0_d;
    end
    for (int j = 1; j <= DIV_STEPS; j++) begin
      if (adv[j]) begin
        rem_q[j] <= rem_d[j];
        dvs_q[j] <= dvs_q[j-1];
        quo_q[j] <= quo_d[j];
        mag_q[j] <= mag_q[j-1];
      end
    end
  end

  assign valid_o       = vld_q[DIV_STEPS];
  assign hue_degrees_o = quo_q[DIV_STEPS];
  assign magnitude_o   = mag_q[DIV_STEPS];

endmodule

// File: tb/rgb_to_hue_and_magnitude_checker.sv
// Checker for rgb_to_hue_and_magnitude_top: predicts hue and magnitude for every accepted
// color and compares each delivered result, in order, against the oldest prediction.
// Depends on rgbhm_pkg for the field widths.
module rgb_to_hue_and_magnitude_checker
  import rgbhm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [LEVEL_W-1:0] red_i,
  input  logic [LEVEL_W-1:0] green_i,
  input  logic [LEVEL_W-1:0] blue_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [HUE_W-1:0]   hue_i,
  input  logic [MAG_W-1:0]   magnitude_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LOG10_2_Q32 = 64'd1292913987;
  localparam int          LOG2_BITS   = 28;
  localparam int          REPORT_MAX  = 10;

  typedef struct {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [HUE_W-1:0]   hue;
    logic [MAG_W-1:0]   magnitude;
  } color_result_t;

  color_result_t awaited_colors[$];
  int unsigned   mismatches = 0;

  // Hue measured backwards from 360, rounded half up; gray gives 360.
  function automatic logic [HUE_W-1:0] inverted_hue(input int r, input int g, input int b,
                                                    input int mx, input int mn);
    int d;
    int num;
    d = mx - mn;
    if (d == 0) begin
      return HUE_W'(360);
    end
    if (mx == r) begin
      num = (g >= b) ? 360 * d - 60 * (g - b) : 60 * (b - g);
    end else if (mx == g) begin
      num = 240 * d - 60 * (b - r);
    end else begin
      num = 120 * d - 60 * (r - g);
    end
    if (num < 0) begin
      num = 0;
    end
    return HUE_W'((2 * num + d) / (2 * d));
  endfunction

  // Lightness in hundredths of a percent from max+min, then a fixed-point log10
  // built from repeated squaring of a Q30 mantissa.
  function automatic logic [MAG_W-1:0] lightness_magnitude(input int unsigned sum);
    logic [63:0] full;
    logic [63:0] lh;
    logic [63:0] num;
    logic [63:0] m;
    logic [63:0] l2;
    logic [63:0] t;
    logic [63:0] res;
    int unsigned k;
    full = 64'd100 << FRAC_BITS;
    lh   = (64'd2000 * 64'(sum) + 64'd51) / 64'd102;
    if (lh <= 64'd5800) begin
      res = full;
    end else if (lh >= 64'd9000) begin
      res = 64'd0;
    end else begin
      num = 64'd3200 + 64'd9 * (lh - 64'd5800);
      k = 0;
      while (k < 3 && num >= (64'd3200 << (k + 1))) begin
        k++;
      end
      m  = (num << 30) / (64'd3200 << k);
      l2 = 64'(k) << LOG2_BITS;
      for (int i = LOG2_BITS - 1; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m     = m >> 1;
          l2[i] = 1'b1;
        end
      end
      t = (l2 * LOG10_2_Q32) >> LOG2_BITS;
      if (t >= (64'd1 << 32)) begin
        res = 64'd0;
      end else begin
        res = (full * ((64'd1 << 32) - t) + (64'd1 << 31)) >> 32;
      end
    end
    return res[MAG_W-1:0];
  endfunction

  function automatic color_result_t predict_color(input logic [LEVEL_W-1:0] r,
                                                  input logic [LEVEL_W-1:0] g,
                                                  input logic [LEVEL_W-1:0] b);
    color_result_t res;
    int mx;
    int mn;
    mx = int'(r);
    mn = int'(r);
    if (int'(g) > mx) mx = int'(g);
    if (int'(b) > mx) mx = int'(b);
    if (int'(g) < mn) mn = int'(g);
    if (int'(b) < mn) mn = int'(b);
    res.red       = r;
    res.green     = g;
    res.blue      = b;
    res.hue       = inverted_hue(int'(r), int'(g), int'(b), mx, mn);
    res.magnitude = lightness_magnitude(mx + mn);
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk_i) begin : check_edge
    color_result_t oldest;
    if (rst_ni) begin
      // Retire first so that a result never matches an item taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_colors.size() == 0) begin
          note_failure($sformatf("result with no item outstanding: hue %0d magnitude %0d",
                                 hue_i, magnitude_i));
        end else begin
          oldest = awaited_colors.pop_front();
          if (oldest.hue !== hue_i || oldest.magnitude !== magnitude_i) begin
            note_failure($sformatf(
                "mismatch for rgb (%0d,%0d,%0d): hue exp %0d got %0d, magnitude exp %0d got %0d",
                oldest.red, oldest.green, oldest.blue, oldest.hue, hue_i,
                oldest.magnitude, magnitude_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_colors.push_back(predict_color(red_i, green_i, blue_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_colors.size();
  end

endmodule

// File: tb/rgb_to_hue_and_magnitude_top_tb.sv
// Testbench top for rgb_to_hue_and_magnitude_top: drives colors and receiver stalls
// in three idling phases and gives the verdict. Depends on rgbhm_pkg, the block
// and rgb_to_hue_and_magnitude_checker.
module rgb_to_hue_and_magnitude_top_tb;
  import rgbhm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned SETTLE_LIMIT = 16;
  localparam int unsigned DIRECTED_N   = 22;

  // Colors packed as {red, green, blue}: extremes, every hue segment, ties,
  // gray, a half-degree rounding case, and sums at the dark and bright edges.
  localparam logic [23:0] DIRECTED[DIRECTED_N] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hC8640A, 24'hC80A64, 24'h0AC864,
    24'h640AC8, 24'hC83232, 24'h780100, 24'h010000, 24'h000001, 24'hFEFFFE,
    24'hC85F96, 24'hC86096, 24'hFFCBE6, 24'hFFCCE6
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               valid_i       = 1'b0;
  logic               stall_o;
  logic [LEVEL_W-1:0] red_level_i   = '0;
  logic [LEVEL_W-1:0] green_level_i = '0;
  logic [LEVEL_W-1:0] blue_level_i  = '0;
  logic               valid_o;
  logic               stall_i       = 1'b0;
  logic [HUE_W-1:0]   hue_degrees_o;
  logic [MAG_W-1:0]   magnitude_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 62;
  int unsigned idle_cycles   = 0;

  always #4 clk_i = ~clk_i;

  rgb_to_hue_and_magnitude_top #(
    .MAG_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .red_level_i  (red_level_i),
    .green_level_i(green_level_i),
    .blue_level_i (blue_level_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .hue_degrees_o(hue_degrees_o),
    .magnitude_o  (magnitude_o)
  );

  rgb_to_hue_and_magnitude_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_i  (stall_o),
    .red_i       (red_level_i),
    .green_i     (green_level_i),
    .blue_i      (blue_level_i),
    .out_valid_i (valid_o),
    .out_stall_i (stall_i),
    .hue_i       (hue_degrees_o),
    .magnitude_i (magnitude_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Counts edges at which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni && ((valid_i && !stall_o) || (valid_o && !stall_i))) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // Returns at the edge where the item is taken, so the caller may drive the
  // next one at that same edge without lowering valid.
  task automatic send_color(input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] g,
                            input logic [LEVEL_W-1:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    valid_i       <= 1'b1;
    red_level_i   <= r;
    green_level_i <= g;
    blue_level_i  <= b;
    do @(posedge clk_i); while (stall_o);
  endtask

  task automatic send_random_color();
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
    int unsigned        pick;
    pick = $urandom_range(9);
    r = LEVEL_W'($urandom_range(255));
    g = LEVEL_W'($urandom_range(255));
    b = LEVEL_W'($urandom_range(255));
    if (pick < 2) begin
      g = r;
      b = r;
    end else if (pick < 4) begin
      case ($urandom_range(2))
        0:       g = r;
        1:       b = g;
        default: b = r;
      endcase
    end else if (pick < 7) begin
      // Bright colors put max+min across the logarithmic part of the magnitude.
      r = LEVEL_W'($urandom_range(255, 150));
      g = LEVEL_W'($urandom_range(255, 150));
      b = LEVEL_W'($urandom_range(255, 100));
    end
    send_color(r, g, b);
  endtask

  task automatic wait_for_drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 38 : 0;
      if (phase == 0) begin
        foreach (DIRECTED[i]) begin
          send_color(DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_color();
        if (phase == 0 && n == PHASE_ITEMS / 2) begin
          wait_for_drain();
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE_LIMIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
